@@ hw/rtl/fftmag_pkg.sv @@
// Shared types, constants and the twiddle lookup of the FFT magnitude unit.
`default_nettype none
package fftmag_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned PointW  = 24;
  localparam int unsigned MagW    = 16;
  localparam int unsigned BinW    = 6;
  localparam int unsigned TwW     = 16;

  typedef logic signed [TwW-1:0] tw_val_t;

  typedef struct packed {
    tw_val_t wr;
    tw_val_t wi;
  } twiddle_t;

  // Quarter cosine wave of a 64-point transform; 1.0 is held as 32767.
  function automatic tw_val_t quarter_cos(input logic [4:0] k);
    tw_val_t v;
    case (k)
      5'd0:    v = 16'sd32767;
      5'd1:    v = 16'sd32610;
      5'd2:    v = 16'sd32138;
      5'd3:    v = 16'sd31357;
      5'd4:    v = 16'sd30274;
      5'd5:    v = 16'sd28899;
      5'd6:    v = 16'sd27246;
      5'd7:    v = 16'sd25330;
      5'd8:    v = 16'sd23170;
      5'd9:    v = 16'sd20788;
      5'd10:   v = 16'sd18205;
      5'd11:   v = 16'sd15447;
      5'd12:   v = 16'sd12540;
      5'd13:   v = 16'sd9512;
      5'd14:   v = 16'sd6393;
      5'd15:   v = 16'sd3212;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // Twiddle exp(-j*2*pi*k/64) for k in 0..31.
  function automatic twiddle_t twiddle(input logic [4:0] k);
    twiddle_t t;
    if (k <= 5'd16) begin
      t.wr = quarter_cos(k);
      t.wi = -quarter_cos(5'd16 - k);
    end else begin
      t.wr = -quarter_cos(5'd0 - k);
      t.wi = -quarter_cos(k - 5'd16);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fft_single_sided_magnitude_unit.sv @@
// Top level of the FFT single-sided magnitude unit.
//
// Usage: samples arrive as words on the s_ channel (tdata = 16-bit signed sample).
// N = 2**size_log2 words (size_log2 clamped to 1..6) make one frame; they are written
// in bit-reversed order into a 48-bit point memory with a registered read. After the
// N-th word the unit runs an in-place radix-2 FFT with one shared butterfly that steps
// through read a, read b, hold b, multiply, write a and write b for each pair.
// It then emits N/2+1 bins on the m_ channel, each through read, wait, square, sum,
// 24 square root steps and output.
// s_tready is high only while loading and no cfg word is offered; a word is taken
// every cycle there.
// The output register lets the next bin be computed while a bin waits; a stalled
// receiver holds the unit before the following bin.
// The cfg channel sets size_log2 and restarts loading; it is ready only while loading.
// Reset sets size_log2 to 6, clears the load count and empties the output.
`default_nettype none
module fft_single_sided_magnitude_unit #(
  parameter int unsigned POINTS_MAX = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [15:0] magnitude, [21:16] bin_index, [23:22] zero
  output logic             m_tlast,   // last_bin
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data
);

  localparam int unsigned AW     = $clog2(POINTS_MAX + 1) - 1;
  localparam logic [2:0]  MAX_LG = 3'(AW);
  localparam int unsigned PW     = fftmag_pkg::PointW;

  typedef enum logic [3:0] {
    S_LOAD, S_BF_RA, S_BF_RB, S_BF_CA, S_BF_MUL, S_BF_ADD, S_BF_WB,
    S_MG_RD, S_MG_WAIT, S_MG_SQ, S_MG_SUM, S_MG_SQRT, S_MG_OUT
  } state_t;

  state_t state;

  logic [2:0]    size_log2;
  logic [2:0]    lg;
  logic [AW:0]   load_count;
  logic [AW:0]   n_pts;
  logic [AW-1:0] half;

  logic [2:0]    stage;
  logic [AW-2:0] bfly;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] idx_b;
  logic [AW-1:0] low_mask;
  logic [AW-1:0] low_part;
  logic [5:0]    k_tw;
  fftmag_pkg::twiddle_t tw;
  fftmag_pkg::twiddle_t tw_now;

  logic [47:0]   mem [POINTS_MAX];
  logic [AW-1:0] rd_addr;
  logic [47:0]   rdata;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [47:0]   wr_data;

  logic signed [PW-1:0] a_re, a_im;
  logic signed [PW-1:0] b_re, b_im;
  logic signed [39:0]   p_rr, p_ii, p_ri, p_ir;
  logic signed [40:0]   pr_sum, pi_sum;
  logic signed [PW-1:0] pr, pim;
  logic signed [PW-1:0] x_re, x_im;

  logic [AW-1:0] bin;
  logic signed [47:0] sq_re, sq_im;
  logic [47:0]   rad;
  logic [25:0]   rem;
  logic [23:0]   root;
  logic [4:0]    sq_cnt;
  logic [27:0]   rem_sh;
  logic [27:0]   trial;
  logic [23:0]   root_sh;

  logic [AW-1:0] rev_full;
  logic [AW-1:0] load_addr;
  logic          in_fire;
  logic          out_free;

  always_comb begin
    if (size_log2 == 3'd0) begin
      lg = 3'd1;
    end else if (size_log2 > MAX_LG) begin
      lg = MAX_LG;
    end else begin
      lg = size_log2;
    end
    n_pts = (AW+1)'(1) << lg;
    half  = AW'(n_pts >> 1);
  end

  // Samples go straight to their bit-reversed place.
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = load_count[AW-1-b];
    end
    load_addr = rev_full >> (3'(AW) - lg);
  end

  always_comb begin
    low_mask = (AW'(1) << stage) - AW'(1);
    low_part = AW'(bfly) & low_mask;
    idx_a    = ((AW'(bfly) & ~low_mask) << 1) | low_part;
    idx_b    = idx_a | (AW'(1) << stage);
    k_tw     = 6'(low_part) << (3'd5 - stage);
    tw_now   = fftmag_pkg::twiddle(k_tw[4:0]);
  end

  assign s_tready  = (state == S_LOAD) && !cfg_valid;
  assign cfg_ready = (state == S_LOAD);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    x_re   = rdata[PW-1:0];
    x_im   = rdata[2*PW-1:PW];
    pr_sum = (41'(p_rr) - 41'(p_ii) + 41'sd16384) >>> 15;
    pi_sum = (41'(p_ri) + 41'(p_ir) + 41'sd16384) >>> 15;
    pr     = pr_sum[PW-1:0];
    pim    = pi_sum[PW-1:0];
    rem_sh = {rem, rad[47:46]};
    trial  = {root, 2'b01};
  end

  always_comb begin
    case (state)
      S_BF_RA:          rd_addr = idx_a;
      S_BF_RB, S_BF_CA: rd_addr = idx_b;
      default:          rd_addr = bin;
    endcase
    wr_en   = 1'b0;
    wr_addr = idx_a;
    wr_data = {a_im + pim, a_re + pr};
    case (state)
      S_LOAD: begin
        wr_en   = in_fire;
        wr_addr = load_addr;
        wr_data = {{PW{1'b0}}, PW'(signed'(s_tdata))};
      end
      S_BF_ADD: begin
        wr_en = 1'b1;
      end
      S_BF_WB: begin
        wr_en   = 1'b1;
        wr_addr = idx_b;
        wr_data = {b_im, b_re};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    root_sh = {root[22:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      size_log2  <= 3'd6;
      load_count <= '0;
      stage      <= '0;
      bfly       <= '0;
      bin        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == S_MG_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (cfg_valid && cfg_ready) begin
            size_log2  <= cfg_data;
            load_count <= '0;
          end else if (in_fire) begin
            if (load_count + (AW+1)'(1) == n_pts) begin
              load_count <= '0;
              stage      <= '0;
              bfly       <= '0;
              state      <= S_BF_RA;
            end else begin
              load_count <= load_count + (AW+1)'(1);
            end
          end
        end
        S_BF_RA: begin
          tw    <= tw_now;
          state <= S_BF_RB;
        end
        S_BF_RB: begin
          a_re  <= x_re;
          a_im  <= x_im;
          state <= S_BF_CA;
        end
        S_BF_CA: begin
          state <= S_BF_MUL;
        end
        S_BF_MUL: begin
          p_rr  <= x_re * tw.wr;
          p_ii  <= x_im * tw.wi;
          p_ri  <= x_re * tw.wi;
          p_ir  <= x_im * tw.wr;
          state <= S_BF_ADD;
        end
        S_BF_ADD: begin
          b_re  <= a_re - pr;
          b_im  <= a_im - pim;
          state <= S_BF_WB;
        end
        S_BF_WB: begin
          if (AW'(bfly) == half - AW'(1)) begin
            bfly <= '0;
            if (stage == lg - 3'd1) begin
              bin   <= '0;
              state <= S_MG_RD;
            end else begin
              stage <= stage + 3'd1;
              state <= S_BF_RA;
            end
          end else begin
            bfly  <= bfly + (AW-1)'(1);
            state <= S_BF_RA;
          end
        end
        S_MG_RD: begin
          state <= S_MG_WAIT;
        end
        S_MG_WAIT: begin
          state <= S_MG_SQ;
        end
        S_MG_SQ: begin
          sq_re <= x_re * x_re;
          sq_im <= x_im * x_im;
          state <= S_MG_SUM;
        end
        S_MG_SUM: begin
          rad    <= sq_re + sq_im;
          rem    <= '0;
          root   <= '0;
          sq_cnt <= 5'd23;
          state  <= S_MG_SQRT;
        end
        S_MG_SQRT: begin
          // One root bit per cycle, two radicand bits consumed.
          if (rem_sh >= trial) begin
            rem  <= 26'(rem_sh - trial);
            root <= root_sh | 24'd1;
          end else begin
            rem  <= rem_sh[25:0];
            root <= root_sh;
          end
          rad <= {rad[45:0], 2'b00};
          if (sq_cnt == 5'd0) begin
            state <= S_MG_OUT;
          end else begin
            sq_cnt <= sq_cnt - 5'd1;
          end
        end
        S_MG_OUT: begin
          if (out_free) begin
            if ((root >> (lg - 3'd1)) > 24'd65535) begin
              m_tdata[15:0] <= 16'hFFFF;
            end else begin
              m_tdata[15:0] <= 16'(root >> (lg - 3'd1));
            end
            m_tdata[21:16] <= 6'(bin);
            m_tdata[23:22] <= 2'b00;
            m_tlast        <= (bin == half);
            if (bin == half) begin
              state <= S_LOAD;
            end else begin
              bin   <= bin + AW'(1);
              state <= S_MG_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_stage_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BF_RA) |-> (stage < lg))
    else $error("butterfly stage beyond transform length");

  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MG_RD) |-> (bin <= half))
    else $error("bin beyond Nyquist");

  a_load_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (load_count < n_pts))
    else $error("load count beyond frame length");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_MG_OUT && out_free && bin == half) |=> (state == S_LOAD && m_tlast))
    else $error("last bin did not end the run");

endmodule
`default_nettype wire

@@ tb/fftmag_checker.sv @@
// Checker of the FFT magnitude unit: watches the channels, predicts bins and compares them.
`timescale 1ns / 1ps
`default_nettype none
module fftmag_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,
  input  wire logic        m_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_data,
  output int               errors,
  output int               bins_pending
);
  localparam int MagW   = fftmag_pkg::MagW;
  localparam int BinW   = fftmag_pkg::BinW;
  localparam int PointW = fftmag_pkg::PointW;

  typedef struct {
    logic [MagW-1:0] magnitude;
    logic [BinW-1:0] bin_index;
    logic            last_bin;
  } bin_word_t;

  bin_word_t bins_due[$];

  logic signed [PointW-1:0] frame_re [64];
  logic [6:0]               frame_fill;
  logic [2:0]               size_reg;

  // Quarter cosine of a 64-point transform in Q1.15, 1.0 held as 32767.
  int cos_q [17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                     20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

  assign bins_pending = bins_due.size();

  function automatic int active_log2();
    if (size_reg < 3'd1) return 1;
    if (size_reg > 3'd6) return 6;
    return int'(size_reg);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // Runs the fixed-point transform on the loaded frame and queues its bins.
  task automatic spectrum_of_frame(input int lg);
    logic signed [PointW-1:0] tr [64];
    logic signed [PointW-1:0] ti [64];
    int n, span, stride, k, j, rev;
    longint wr, wi, xr, xi, pr, pi, ar, ai, re, im;
    longint unsigned mag;
    bin_word_t b;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      rev = 0;
      for (int q = 0; q < lg; q++)
        if (i[q]) rev |= 1 << (lg - 1 - q);
      tr[i] = frame_re[rev];
      ti[i] = '0;
    end
    for (int stage = 0; stage < lg; stage++) begin
      span = 1 << stage;
      stride = 64 >> (stage + 1);
      for (int i = 0; i < n; i++) begin
        if ((i & span) == 0) begin
          k = ((i & (span - 1)) * stride) & 31;
          wr = (k <= 16) ? cos_q[k] : -cos_q[32 - k];
          wi = -((k <= 16) ? cos_q[16 - k] : cos_q[k - 16]);
          j = i + span;
          xr = tr[j];
          xi = ti[j];
          // Adding 16384 before the flooring arithmetic shift rounds to nearest, as the unit does.
          pr = (xr * wr - xi * wi + 16384) >>> 15;
          pi = (xr * wi + xi * wr + 16384) >>> 15;
          ar = tr[i];
          ai = ti[i];
          tr[i] = PointW'(ar + pr);
          ti[i] = PointW'(ai + pi);
          tr[j] = PointW'(ar - pr);
          ti[j] = PointW'(ai - pi);
        end
      end
    end
    for (int q = 0; q <= n / 2; q++) begin
      re = tr[q];
      im = ti[q];
      mag = root_floor(longint'(re * re + im * im)) >> (lg - 1);
      b.magnitude = (mag > 65535) ? 16'hFFFF : mag[15:0];
      b.bin_index = BinW'(q);
      b.last_bin = (q == n / 2);
      bins_due.push_back(b);
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    bin_word_t b;
    int lg;
    if (rst) begin
      frame_fill <= '0;
      size_reg <= 3'd6;
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_reg <= cfg_data;
        frame_fill <= '0;
      end else if (s_tvalid && s_tready) begin
        lg = active_log2();
        if (frame_fill >= (1 << lg)) begin
          frame_re[0] = PointW'($signed(s_tdata));
          frame_fill <= 7'd1;
        end else begin
          frame_re[frame_fill] = PointW'($signed(s_tdata));
          if (frame_fill + 1 == (1 << lg)) begin
            frame_fill <= '0;
            spectrum_of_frame(lg);
          end else begin
            frame_fill <= frame_fill + 7'd1;
          end
        end
      end
      if (m_tvalid && m_tready) begin
        if (bins_due.size() == 0) begin
          report("unexpected word, bin", m_tdata[21:16], -1);
        end else begin
          b = bins_due.pop_front();
          if (m_tdata[15:0] != b.magnitude)
            report("magnitude", m_tdata[15:0], b.magnitude);
          if (m_tdata[21:16] != b.bin_index)
            report("bin_index", m_tdata[21:16], b.bin_index);
          if (m_tlast != b.last_bin)
            report("last_bin", m_tlast, b.last_bin);
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Top of the FFT magnitude unit testbench: stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  localparam int CycleLimit = 100000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;
  int          errors;
  int          bins_pending;
  int          cycles = 0;
  bit          calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fft_single_sided_magnitude_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  fftmag_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .bins_pending(bins_pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: a fresh random stall, possibly none, before every word, none while calm.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  task automatic send_sample(input logic [15:0] value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  // Register writes happen only once the unit has drained and settled.
  task automatic set_size(input logic [2:0] value);
    s_tvalid <= 1'b0;
    while (bins_pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample(input int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 511) - 256);
      default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  initial begin
    int sizes [8] = '{6, 7, 0, 1, 2, 3, 4, 5};
    int frames [8] = '{1, 1, 4, 4, 4, 3, 2, 1};
    int n, style, lg;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: a partial frame dropped by a register write, then extremes.
    set_size(3'd2);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    set_size(3'd1);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    set_size(3'd2);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'h0000);
    set_size(3'd3);
    for (int i = 0; i < 8; i++) send_sample(16'h8000);

    // Random phases over every register value, each possibly ending in a dropped tail.
    for (int p = 0; p < 8; p++) begin
      set_size(3'(sizes[p]));
      calm = ($urandom_range(0, 3) == 0);
      lg = (sizes[p] < 1) ? 1 : (sizes[p] > 6) ? 6 : sizes[p];
      n = 1 << lg;
      for (int f = 0; f < frames[p]; f++) begin
        style = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
          send_sample(pick_sample(style < 3 ? 0 : style - 2));
      end
      if ($urandom_range(0, 1) != 0)
        repeat ($urandom_range(1, n - 1)) send_sample(pick_sample(0));
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (bins_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
